// ===== rtl/core/computed_torque_diff_drive_core_macros.svh =====
// Assertion macros for the differential-drive torque core.
// Included by the top level; no other dependencies.
`ifndef COMPUTED_TORQUE_DIFF_DRIVE_CORE_MACROS_SVH
`define COMPUTED_TORQUE_DIFF_DRIVE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CTDD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CTDD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CTDD_ASSERT_NOW(label, ante, cons)
`define CTDD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/ctdd_pkg.sv =====
// Shared constants and helpers for the differential-drive torque core.
// No dependencies.
`timescale 1ns / 1ps
package ctdd_pkg;
    localparam int ERPM_TO_RADS_Q16_DEF = 980;
    localparam int HALF_RADIUS_Q16_DEF  = 3277;
    localparam int TURN_SCALE_Q16_DEF   = 16384;
    localparam int TICK_Q16_DEF         = 655;

    // multiplier operand width, wide enough for a sum of two Q16.16 words
    localparam int MUL_W = 34;
    // width of internal sums of rounded products
    localparam int SUM_W = 56;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = -SUM_W'(32'sh7FFF_FFFF) - SUM_W'(1);
        if (x > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction
endpackage

// ===== rtl/core/computed_torque_diff_drive_core.sv =====
// Computed-torque controller for a differential-drive base, Q16.16.
// Sequence: 20 multiplies, one at a time on the single bit-serial multiplier, from accept
// to word valid; a new input word is accepted only after the last result is registered,
// and a stalled result word holds off the next accept.
// Reset (synchronous, active low) clears configuration registers, valid, wheel angles and goal positions.
// Depends on ctdd_pkg, ctdd_mul and the macros header.
`timescale 1ns / 1ps
`include "computed_torque_diff_drive_core_macros.svh"
module computed_torque_diff_drive_core
    import ctdd_pkg::*;
#(
    parameter int ERPM_TO_RADS_Q16 = ERPM_TO_RADS_Q16_DEF,
    parameter int HALF_RADIUS_Q16  = HALF_RADIUS_Q16_DEF,
    parameter int TURN_SCALE_Q16   = TURN_SCALE_Q16_DEF,
    parameter int TICK_Q16         = TICK_Q16_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input words
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [17:0] i_erpm_left,
    input  logic signed [17:0] i_erpm_right,
    input  logic signed [31:0] i_target_vx,
    input  logic signed [31:0] i_target_wz,
    input  logic [30:0]        i_kp_fwd,
    input  logic [30:0]        i_kd_fwd,
    input  logic [30:0]        i_kp_rot,
    input  logic [30:0]        i_kd_rot,
    // result words
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_current_left,
    output logic signed [31:0] o_current_right,
    output logic signed [31:0] o_vel_fwd,
    output logic signed [31:0] o_vel_rot,
    output logic signed [31:0] o_pos_fwd,
    output logic signed [31:0] o_pos_rot
);
    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_WAIT, ST_DONE} t_state;
    typedef enum logic [4:0] {
        SP_RL, SP_RR, SP_AL, SP_AR, SP_VF, SP_VR, SP_PF, SP_PR, SP_GF, SP_GR,
        SP_DF, SP_PFW, SP_DR, SP_PRT, SP_ILF, SP_ILR, SP_FL, SP_IRF, SP_IRR, SP_FR
    } t_step;
    typedef enum logic [2:0] {
        RG_DIR_L, RG_DIR_R, RG_ILF, RG_ILR, RG_IRF, RG_IRR, RG_FL, RG_FR
    } t_reg;

    // configuration registers
    logic               r_dir_l, r_dir_r;
    logic signed [31:0] r_ilf, r_ilr, r_irf, r_irr, r_fl, r_fr;
    // controller state
    logic signed [31:0] r_ang_l, r_ang_r, r_goal_f, r_goal_r;
    // captured input word
    logic signed [17:0] r_el, r_er;
    logic signed [31:0] r_tvx, r_twz;
    logic [30:0]        r_kpf, r_kdf, r_kpr, r_kdr;
    // intermediates
    logic signed [31:0] r_rl, r_rr, r_vf, r_vr, r_pf, r_pr, r_af, r_ar, r_cl, r_cr;
    logic signed [SUM_W-1:0] r_t;
    // sequencer and output
    t_state             r_state;
    t_step              r_step;
    logic               r_oval;
    logic signed [31:0] r_o_cl, r_o_cr, r_o_vf, r_o_vr, r_o_pf, r_o_pr;

    logic                       w_start, w_done, w_cfg_wr, w_in_acc;
    logic signed [MUL_W-1:0]    w_a, w_b;
    logic signed [2*MUL_W-1:0]  w_prod, w_rp;
    logic signed [SUM_W-1:0]    w_rnd, w_rate;

    // sign-extend 32-bit values to operand width
    function automatic logic signed [MUL_W-1:0] ext(input logic signed [31:0] x);
        ext = MUL_W'(x);
    endfunction

    function automatic logic signed [MUL_W-1:0] err(input logic signed [31:0] x,
                                                     input logic signed [31:0] y);
        err = ext(sat32(SUM_W'(x) - SUM_W'(y)));
    endfunction

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_in_acc = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign w_start  = (r_state == ST_LOAD);

    // register read mux
    always_comb begin
        case (t_reg'(paddr[4:2]))
            RG_DIR_L: prdata = {31'd0, r_dir_l};
            RG_DIR_R: prdata = {31'd0, r_dir_r};
            RG_ILF:   prdata = r_ilf;
            RG_ILR:   prdata = r_ilr;
            RG_IRF:   prdata = r_irf;
            RG_IRR:   prdata = r_irr;
            RG_FL:    prdata = r_fl;
            RG_FR:    prdata = r_fr;
            default:  prdata = '0;
        endcase
    end

    // operand select per step
    always_comb begin
        case (r_step)
            SP_RL:   begin w_a = MUL_W'(r_el); w_b = MUL_W'(ERPM_TO_RADS_Q16); end
            SP_RR:   begin w_a = MUL_W'(r_er); w_b = MUL_W'(ERPM_TO_RADS_Q16); end
            SP_AL:   begin w_a = ext(r_rl); w_b = MUL_W'(TICK_Q16); end
            SP_AR:   begin w_a = ext(r_rr); w_b = MUL_W'(TICK_Q16); end
            SP_VF:   begin w_a = ext(r_rl) + ext(r_rr); w_b = MUL_W'(HALF_RADIUS_Q16); end
            SP_VR:   begin w_a = ext(r_rr) - ext(r_rl); w_b = MUL_W'(TURN_SCALE_Q16); end
            SP_PF:   begin
                w_a = ext(r_ang_l) + ext(r_ang_r); w_b = MUL_W'(HALF_RADIUS_Q16);
            end
            SP_PR:   begin
                w_a = ext(r_ang_r) - ext(r_ang_l); w_b = MUL_W'(TURN_SCALE_Q16);
            end
            SP_GF:   begin w_a = ext(r_tvx); w_b = MUL_W'(TICK_Q16); end
            SP_GR:   begin w_a = ext(r_twz); w_b = MUL_W'(TICK_Q16); end
            SP_DF:   begin w_a = err(r_tvx, r_vf); w_b = MUL_W'(r_kdf); end
            SP_PFW:  begin w_a = err(r_goal_f, r_pf); w_b = MUL_W'(r_kpf); end
            SP_DR:   begin w_a = err(r_twz, r_vr); w_b = MUL_W'(r_kdr); end
            SP_PRT:  begin w_a = err(r_goal_r, r_pr); w_b = MUL_W'(r_kpr); end
            SP_ILF:  begin w_a = ext(r_ilf); w_b = ext(r_af); end
            SP_ILR:  begin w_a = ext(r_ilr); w_b = ext(r_ar); end
            SP_FL:   begin w_a = ext(r_fl); w_b = ext(r_rl); end
            SP_IRF:  begin w_a = ext(r_irf); w_b = ext(r_af); end
            SP_IRR:  begin w_a = ext(r_irr); w_b = ext(r_ar); end
            SP_FR:   begin w_a = ext(r_fr); w_b = ext(r_rr); end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    ctdd_mul #(.W(MUL_W)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_done (w_done),
        .o_prod (w_prod)
    );

    // round half up on dropping 16 fraction bits
    assign w_rp   = w_prod + (2*MUL_W)'(32768);
    assign w_rnd  = SUM_W'(w_rp >>> 16);
    // wheel rate with direction sign
    assign w_rate = ((r_step == SP_RL) ? r_dir_l : r_dir_r)
                    ? -SUM_W'(w_prod) : SUM_W'(w_prod);

    // sequencer, write-back, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= SP_RL;
            r_oval   <= 1'b0;
            r_dir_l  <= 1'b0;
            r_dir_r  <= 1'b0;
            r_ilf    <= '0;
            r_ilr    <= '0;
            r_irf    <= '0;
            r_irr    <= '0;
            r_fl     <= '0;
            r_fr     <= '0;
            r_ang_l  <= '0;
            r_ang_r  <= '0;
            r_goal_f <= '0;
            r_goal_r <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (t_reg'(paddr[4:2]))
                    RG_DIR_L: r_dir_l <= pwdata[0];
                    RG_DIR_R: r_dir_r <= pwdata[0];
                    RG_ILF:   r_ilf   <= pwdata;
                    RG_ILR:   r_ilr   <= pwdata;
                    RG_IRF:   r_irf   <= pwdata;
                    RG_IRR:   r_irr   <= pwdata;
                    RG_FL:    r_fl    <= pwdata;
                    RG_FR:    r_fr    <= pwdata;
                    default:  ;
                endcase
            end
            // the finishing state sets valid itself
            if (r_oval && !i_stall && (r_state != ST_DONE)) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_el    <= i_erpm_left;
                        r_er    <= i_erpm_right;
                        r_tvx   <= i_target_vx;
                        r_twz   <= i_target_wz;
                        r_kpf   <= i_kp_fwd;
                        r_kdf   <= i_kd_fwd;
                        r_kpr   <= i_kp_rot;
                        r_kdr   <= i_kd_rot;
                        r_step  <= SP_RL;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (w_done) begin
                        case (r_step)
                            SP_RL:  r_rl <= sat32(w_rate);
                            SP_RR:  r_rr <= sat32(w_rate);
                            SP_AL:  r_ang_l <= sat32(SUM_W'(r_ang_l) + w_rnd);
                            SP_AR:  r_ang_r <= sat32(SUM_W'(r_ang_r) + w_rnd);
                            SP_VF:  r_vf <= sat32(w_rnd);
                            SP_VR:  r_vr <= sat32(w_rnd);
                            SP_PF:  r_pf <= sat32(w_rnd);
                            SP_PR:  r_pr <= sat32(w_rnd);
                            SP_GF:  r_goal_f <= sat32(SUM_W'(r_goal_f) + w_rnd);
                            SP_GR:  r_goal_r <= sat32(SUM_W'(r_goal_r) + w_rnd);
                            SP_DF:  r_t <= w_rnd;
                            SP_PFW: r_af <= sat32(r_t + w_rnd);
                            SP_DR:  r_t <= w_rnd;
                            SP_PRT: r_ar <= sat32(r_t + w_rnd);
                            SP_ILF: r_t <= w_rnd;
                            SP_ILR: r_t <= r_t + w_rnd;
                            SP_FL:  r_cl <= sat32(r_t + w_rnd);
                            SP_IRF: r_t <= w_rnd;
                            SP_IRR: r_t <= r_t + w_rnd;
                            SP_FR:  r_cr <= sat32(r_t + w_rnd);
                            default: ;
                        endcase
                        if (r_step == SP_FR) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_step  <= t_step'(r_step + 5'd1);
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_DONE: begin
                    if (!r_oval || !i_stall) begin
                        r_o_cl  <= r_cl;
                        r_o_cr  <= r_cr;
                        r_o_vf  <= r_vf;
                        r_o_vr  <= r_vr;
                        r_o_pf  <= r_pf;
                        r_o_pr  <= r_pr;
                        r_oval  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid         = r_oval;
    assign o_current_left  = r_o_cl;
    assign o_current_right = r_o_cr;
    assign o_vel_fwd       = r_o_vf;
    assign o_vel_rot       = r_o_vr;
    assign o_pos_fwd       = r_o_pf;
    assign o_pos_rot       = r_o_pr;

    // multiplier finishes only while the sequencer waits for it
    `CTDD_ASSERT_NOW(a_done_in_wait, w_done, r_state == ST_WAIT)
    // an accepted word starts the multiply sequence at the first step
    `CTDD_ASSERT_NEXT(a_accept_starts, w_in_acc, r_state == ST_LOAD && r_step == SP_RL)
    // a new result appears only out of the finishing state
    `CTDD_ASSERT_NOW(a_rise_from_done, $rose(r_oval), $past(r_state) == ST_DONE)
endmodule

// ===== rtl/core/ctdd_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Uses ctdd_pkg for the operand width default.
`timescale 1ns / 1ps
module ctdd_mul
    import ctdd_pkg::*;
#(
    parameter int W = MUL_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic                  o_done,
    output logic signed [2*W-1:0] o_prod
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic signed [2*W-1:0] r_acc;
    logic signed [2*W-1:0] r_mc;
    logic [W-1:0]          r_mr;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic signed [2*W-1:0] w_add;
    logic                  w_last;

    assign w_add  = r_mr[0] ? r_mc : '0;
    assign w_last = (r_cnt == CW'(W - 1));

    // shift-add; the sign bit of the multiplier carries negative weight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_mc   <= (2*W)'(i_a);
                r_mr   <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= w_last ? (r_acc - w_add) : (r_acc + w_add);
                r_mc  <= r_mc <<< 1;
                r_mr  <= r_mr >> 1;
                r_cnt <= r_cnt + CW'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== tb/sv/tb_ctdd_regs_pkg.sv =====
// Register map of the differential-drive torque core, as the testbench sees it.
// No dependencies.
`timescale 1ns / 1ps
package tb_ctdd_regs_pkg;
    typedef enum int {
        REG_DIR_LEFT_NEG      = 0,
        REG_DIR_RIGHT_NEG     = 1,
        REG_INERTIA_LEFT_FWD  = 2,
        REG_INERTIA_LEFT_ROT  = 3,
        REG_INERTIA_RIGHT_FWD = 4,
        REG_INERTIA_RIGHT_ROT = 5,
        REG_FRICTION_LEFT     = 6,
        REG_FRICTION_RIGHT    = 7,
        REG_COUNT             = 8
    } ctdd_reg_e;
endpackage

// ===== tb/sv/ctdd_torque_checker.sv =====
// Checker for the torque core: snoops register writes and both channels,
// predicts current, velocity and position words and compares them.
// Depends on ctdd_pkg and tb_ctdd_regs_pkg.
`timescale 1ns / 1ps
module ctdd_torque_checker
    import ctdd_pkg::*;
    import tb_ctdd_regs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [17:0] i_erpm_left,
    input  logic signed [17:0] i_erpm_right,
    input  logic signed [31:0] i_target_vx,
    input  logic signed [31:0] i_target_wz,
    input  logic [30:0]        i_kp_fwd,
    input  logic [30:0]        i_kd_fwd,
    input  logic [30:0]        i_kp_rot,
    input  logic [30:0]        i_kd_rot,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_current_left,
    input  logic signed [31:0] o_current_right,
    input  logic signed [31:0] o_vel_fwd,
    input  logic signed [31:0] o_vel_rot,
    input  logic signed [31:0] o_pos_fwd,
    input  logic signed [31:0] o_pos_rot,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);
    typedef struct {
        logic signed [31:0] cur_l;
        logic signed [31:0] cur_r;
        logic signed [31:0] vel_f;
        logic signed [31:0] vel_r;
        logic signed [31:0] pos_f;
        logic signed [31:0] pos_r;
    } drive_word_t;

    // shadow configuration and integrator state
    logic   neg_l, neg_r;
    longint j_lf, j_lr, j_rf, j_rr, fric_l, fric_r;
    longint ang_l, ang_r, goal_f, goal_r;
    drive_word_t expected_words[$];

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // drop 16 fraction bits, nearest, ties up
    function automatic longint rnd_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    // one control tick of the controller
    task automatic predict_tick(output drive_word_t w);
        longint rl, rr, vf, vr, pf, pr, tvx, twz, e_v, e_p, acc_f, acc_r;
        tvx = longint'(i_target_vx);
        twz = longint'(i_target_wz);
        rl = longint'(i_erpm_left) * ERPM_TO_RADS_Q16_DEF;
        rr = longint'(i_erpm_right) * ERPM_TO_RADS_Q16_DEF;
        if (neg_l) rl = -rl;
        if (neg_r) rr = -rr;
        rl = clamp32(rl);
        rr = clamp32(rr);
        ang_l = clamp32(ang_l + rnd_q16(rl * TICK_Q16_DEF));
        ang_r = clamp32(ang_r + rnd_q16(rr * TICK_Q16_DEF));
        vf = clamp32(rnd_q16(HALF_RADIUS_Q16_DEF * (rl + rr)));
        vr = clamp32(rnd_q16(TURN_SCALE_Q16_DEF * (rr - rl)));
        pf = clamp32(rnd_q16(HALF_RADIUS_Q16_DEF * (ang_l + ang_r)));
        pr = clamp32(rnd_q16(TURN_SCALE_Q16_DEF * (ang_r - ang_l)));
        goal_f = clamp32(goal_f + rnd_q16(tvx * TICK_Q16_DEF));
        goal_r = clamp32(goal_r + rnd_q16(twz * TICK_Q16_DEF));
        // PD law per axis
        e_v = clamp32(tvx - vf);
        e_p = clamp32(goal_f - pf);
        acc_f = clamp32(rnd_q16(longint'(i_kd_fwd) * e_v) + rnd_q16(longint'(i_kp_fwd) * e_p));
        e_v = clamp32(twz - vr);
        e_p = clamp32(goal_r - pr);
        acc_r = clamp32(rnd_q16(longint'(i_kd_rot) * e_v) + rnd_q16(longint'(i_kp_rot) * e_p));
        // inertia matrix plus viscous friction
        w.cur_l = 32'(clamp32(rnd_q16(j_lf * acc_f) + rnd_q16(j_lr * acc_r)
                              + rnd_q16(fric_l * rl)));
        w.cur_r = 32'(clamp32(rnd_q16(j_rf * acc_f) + rnd_q16(j_rr * acc_r)
                              + rnd_q16(fric_r * rr)));
        w.vel_f = 32'(vf);
        w.vel_r = 32'(vr);
        w.pos_f = 32'(pf);
        w.pos_r = 32'(pr);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v,
                     act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        drive_word_t w;
        if (!i_rst_n) begin
            neg_l = 0; neg_r = 0;
            j_lf = 0; j_lr = 0; j_rf = 0; j_rr = 0; fric_l = 0; fric_r = 0;
            ang_l = 0; ang_r = 0; goal_f = 0; goal_r = 0;
            expected_words.delete();
            o_errors = 0;
            o_checked = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (int'(paddr >> 2))
                    REG_DIR_LEFT_NEG:      neg_l = pwdata[0];
                    REG_DIR_RIGHT_NEG:     neg_r = pwdata[0];
                    REG_INERTIA_LEFT_FWD:  j_lf = longint'(signed'(pwdata));
                    REG_INERTIA_LEFT_ROT:  j_lr = longint'(signed'(pwdata));
                    REG_INERTIA_RIGHT_FWD: j_rf = longint'(signed'(pwdata));
                    REG_INERTIA_RIGHT_ROT: j_rr = longint'(signed'(pwdata));
                    REG_FRICTION_LEFT:     fric_l = longint'(signed'(pwdata));
                    REG_FRICTION_RIGHT:    fric_r = longint'(signed'(pwdata));
                    default: ;
                endcase
            end
            // result words against the oldest prediction
            if (o_valid && !i_stall) begin
                o_checked++;
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected, current_left %0d",
                             $realtime, o_current_left);
                    o_errors++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("current_left", w.cur_l, o_current_left);
                    check_field("current_right", w.cur_r, o_current_right);
                    check_field("vel_fwd", w.vel_f, o_vel_fwd);
                    check_field("vel_rot", w.vel_r, o_vel_rot);
                    check_field("pos_fwd", w.pos_f, o_pos_fwd);
                    check_field("pos_rot", w.pos_r, o_pos_rot);
                end
            end
            // accepted input words, queued at the tail
            if (i_valid && !o_stall) begin
                predict_tick(w);
                expected_words.insert(expected_words.size(), w);
            end
        end
        o_pending = expected_words.size();
    end
endmodule

// ===== tb/sv/tb_computed_torque_diff_drive_core.sv =====
// Top of the torque core testbench: clock, reset, register setup and tick stimulus.
// Depends on ctdd_pkg, tb_ctdd_regs_pkg, ctdd_torque_checker and the core.
`timescale 1ns / 1ps
module tb_computed_torque_diff_drive_core;
    import tb_ctdd_regs_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [17:0] i_erpm_left = '0, i_erpm_right = '0;
    logic signed [31:0] i_target_vx = '0, i_target_wz = '0;
    logic [30:0]        i_kp_fwd = '0, i_kd_fwd = '0, i_kp_rot = '0, i_kd_rot = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_current_left, o_current_right, o_vel_fwd, o_vel_rot;
    logic signed [31:0] o_pos_fwd, o_pos_rot;
    int                 errors, pending, checked;
    bit                 quiet = 1'b0;
    int                 ticks_sent = 0;

    localparam int TICK_LATENCY = 800;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    computed_torque_diff_drive_core dut (.*);

    ctdd_torque_checker checker_i (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .i_valid, .o_stall, .i_erpm_left, .i_erpm_right, .i_target_vx, .i_target_wz,
        .i_kp_fwd, .i_kd_fwd, .i_kp_rot, .i_kd_rot, .o_valid, .i_stall,
        .o_current_left, .o_current_right, .o_vel_fwd, .o_vel_rot, .o_pos_fwd,
        .o_pos_rot, .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    // result side stalls in bursts
    always @(posedge i_clk) begin
        int hold;
        if (hold > 0) begin
            hold--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(0, 17);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic reg_write(input ctdd_reg_e idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(int'(idx) * 4); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // all registers, only with the core idle
    task automatic load_setting(input logic [31:0] vals[8]);
        wait (pending == 0);
        repeat (TICK_LATENCY) @(posedge i_clk);
        for (int r = 0; r < int'(REG_COUNT); r++) reg_write(ctdd_reg_e'(r), vals[r]);
    endtask

    task automatic send_tick(input logic signed [17:0] el, er, input logic signed [31:0] vx,
                             wz, input logic [30:0] kpf, kdf, kpr, kdr);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_erpm_left <= el; i_erpm_right <= er;
        i_target_vx <= vx; i_target_wz <= wz;
        i_kp_fwd <= kpf; i_kd_fwd <= kdf; i_kp_rot <= kpr; i_kd_rot <= kdr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] any32();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] gain31();
        case ($urandom_range(0, 7))
            0: return 31'h7FFF_FFFF;
            1: return '0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 1 << 21));
        endcase
    endfunction

    function automatic logic [17:0] erpm18();
        case ($urandom_range(0, 5))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    initial begin
        logic [31:0] cfg[8];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // moderate setting, directed field extremes
        cfg = '{0, 0, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_8000,
                32'h0000_0100, 32'hFFFF_FF00};
        load_setting(cfg);
        send_tick('0, '0, '0, '0, '0, '0, '0, '0);
        send_tick(18'h1FFFF, 18'h1FFFF, 32'h0001_0000, '0, 31'h1_0000, 31'h1_0000,
                  31'h1_0000, 31'h1_0000);
        send_tick(18'h20000, 18'h20000, 32'hFFFF_0000, '0, 31'h1_0000, 31'h1_0000,
                  31'h1_0000, 31'h1_0000);
        send_tick(18'h1FFFF, 18'h20000, '0, 32'h0001_0000, 31'h100, 31'h100, 31'h100, 31'h100);
        send_tick(18'h20000, 18'h1FFFF, '0, 32'hFFFF_0000, 31'h100, 31'h100, 31'h100, 31'h100);
        send_tick(18'd1, -18'sd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1, '1);
        send_tick(-18'sd1, 18'd1, 32'h8000_0000, 32'h8000_0000, '1, '1, '1, '1);
        send_tick('0, '0, 32'h7FFF_FFFF, 32'h8000_0000, '1, '0, '0, '1);
        send_tick('0, '0, 32'h8000_0000, 32'h7FFF_FFFF, '0, '1, '1, '0);
        for (int k = 0; k < 6; k++)
            send_tick(18'h1FFFF, 18'h1FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0, '0);
        for (int k = 0; k < 4; k++)
            send_tick(18'h20000, 18'h1FFFF, 32'h8000_0000, 32'h8000_0000, '1, '1, '1, '1);
        idle_input();

        // extreme setting, reversed wheels
        cfg = '{1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000};
        load_setting(cfg);
        send_tick(18'h1FFFF, 18'h20000, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1, '1);
        send_tick(18'h20000, 18'h1FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1, '1, '1);
        send_tick(18'd3, 18'd3, 32'd5, 32'd5, 31'd1, 31'd1, 31'd1, 31'd1);
        idle_input();

        // random settings, random ticks; the last phase runs without idling
        for (int ph = 0; ph < 4; ph++) begin
            cfg[REG_DIR_LEFT_NEG] = ph[0];
            cfg[REG_DIR_RIGHT_NEG] = ph[1];
            for (int r = int'(REG_INERTIA_LEFT_FWD); r < int'(REG_COUNT); r++)
                cfg[r] = (ph == 2) ? any32() : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            load_setting(cfg);
            if (ph == 3) quiet = 1'b1;
            for (int k = 0; k < 95; k++)
                send_tick(erpm18(), erpm18(), any32(), any32(), gain31(), gain31(),
                          gain31(), gain31());
            idle_input();
        end

        wait (pending == 0);
        repeat (TICK_LATENCY) @(posedge i_clk);
        $display("tb: %0d control ticks sent, %0d result words checked", ticks_sent, checked);
        $display("tb: six register settings, wheel directions and gain extremes covered");
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ctdd_pkg.sv
rtl/core/ctdd_mul.sv
rtl/core/computed_torque_diff_drive_core.sv
tb/sv/tb_ctdd_regs_pkg.sv
tb/sv/ctdd_torque_checker.sv
tb/sv/tb_computed_torque_diff_drive_core.sv
